@@ rtl/core/gcb_pkg.sv @@
// shared types, constants and microcode encodings for the graph coloring search core
package gcb_pkg;

   localparam int MAX_VERTICES = 16;
   localparam int MAX_COLORS   = 15;
   localparam int VERT_W       = $clog2(MAX_VERTICES);
   localparam int COLOR_W      = $clog2(MAX_COLORS + 1);
   localparam int VCOUNT_W     = VERT_W + 1;
   localparam int CSR_INDEX_W  = 2;
   localparam int CSR_DATA_W   = (VCOUNT_W > COLOR_W) ? VCOUNT_W : COLOR_W;
   localparam int UPC_W        = 4;

   // item op codes
   localparam logic [1:0] OP_LOAD    = 2'd0;
   localparam logic [1:0] OP_RESTART = 2'd1;
   localparam logic [1:0] OP_NEXT    = 2'd2;

   // register indexes
   localparam logic [CSR_INDEX_W-1:0] CSR_VERTEX_COUNT = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_COLOR_COUNT  = 2'd1;

   typedef struct packed {
      logic [1:0]              op;
      logic [VERT_W-1:0]       row_vertex;
      logic [MAX_VERTICES-1:0] row_bits;
   } req_type;

   typedef struct packed {
      logic [VERT_W-1:0]  vertex;
      logic [COLOR_W-1:0] color;
      logic               found;
      logic               last;
   } rsp_type;

   typedef logic [UPC_W-1:0] upc_type;

   typedef enum logic [3:0] {
      UOP_NOP,
      UOP_LOAD_K,
      UOP_INC_COLOR,
      UOP_K_UP,
      UOP_K_DOWN,
      UOP_SET_EXH,
      UOP_SET_SOL,
      UOP_EMIT_NONE,
      UOP_EMIT_SOL,
      UOP_END
   } uop_type;

   typedef enum logic [2:0] {
      COND_NEVER,
      COND_ALWAYS,
      COND_EXH,
      COND_COLOR_ZERO,
      COND_CONFLICT,
      COND_K_LAST,
      COND_K_ZERO,
      COND_K_NOT_LAST
   } cond_type;

   typedef struct packed {
      uop_type  uop;
      cond_type cond;
      logic     wait_out;
      upc_type  target;
   } ctrl_type;

   typedef struct packed {
      logic exhausted;
      logic color_zero;
      logic conflict;
      logic k_last;
      logic k_zero;
      logic out_busy;
   } flags_type;

   // microprogram step addresses
   localparam upc_type STEP_START     = 4'd0;
   localparam upc_type STEP_INC       = 4'd1;
   localparam upc_type STEP_ZERO      = 4'd2;
   localparam upc_type STEP_CHECK     = 4'd3;
   localparam upc_type STEP_LASTV     = 4'd4;
   localparam upc_type STEP_DEEP      = 4'd5;
   localparam upc_type STEP_BACK      = 4'd6;
   localparam upc_type STEP_BACK2     = 4'd7;
   localparam upc_type STEP_EXH       = 4'd8;
   localparam upc_type STEP_EXH_OUT   = 4'd9;
   localparam upc_type STEP_EMIT      = 4'd10;
   localparam upc_type STEP_EMIT_LOOP = 4'd11;
   localparam upc_type STEP_DONE      = 4'd12;

endpackage

@@ rtl/core/graph_coloring_backtrack_search_core.sv @@
// one item at a time: load and restart items act directly on the datapath, a next item runs a microprogram
// of a setup step, then color trials, steps to go deeper and steps to backtrack, then streams
// a solution or the not-found result, and its emit steps stall while the result side holds off;
// the length of the search loop is data dependent
// reset clears the adjacency rows, all colors and the search position,
// and sets vertex_count to 1 and color_count to 3
module graph_coloring_backtrack_search_core import gcb_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  req_type                req_data,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output rsp_type                rsp_data,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_data
);

   logic [VCOUNT_W-1:0] vertex_count_ff;
   logic [COLOR_W-1:0]  color_count_ff;
   logic [VERT_W-1:0]   last_vertex;
   logic                req_fire;
   logic                busy;
   flags_type           flags;
   ctrl_type            ctrl;

   assign req_ready = !busy;
   assign req_fire  = req_valid && req_ready;
   assign csr_ready = 1'b1;

   // out-of-range vertex counts clamp to 1..MAX_VERTICES
   always_comb begin
      if (vertex_count_ff == '0) begin
         last_vertex = '0;
      end else if (vertex_count_ff > VCOUNT_W'(MAX_VERTICES)) begin
         last_vertex = VERT_W'(MAX_VERTICES - 1);
      end else begin
         last_vertex = VERT_W'(vertex_count_ff - VCOUNT_W'(1));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vertex_count_ff <= VCOUNT_W'(1);
         color_count_ff  <= COLOR_W'(3);
      end else if (csr_valid && csr_ready) begin
         if (csr_index == CSR_VERTEX_COUNT) begin
            vertex_count_ff <= csr_data[VCOUNT_W-1:0];
         end else if (csr_index == CSR_COLOR_COUNT) begin
            color_count_ff <= csr_data[COLOR_W-1:0];
         end
      end
   end

   gcb_sequencer u_seq (
      .clock    (clock),
      .reset    (reset),
      .start    (req_fire && req_data.op == OP_NEXT),
      .flags    (flags),
      .busy     (busy),
      .ctrl_out (ctrl)
   );

   gcb_datapath u_dp (
      .clock       (clock),
      .reset       (reset),
      .ctrl        (ctrl),
      .load_row    (req_fire && req_data.op == OP_LOAD),
      .restart     (req_fire && req_data.op == OP_RESTART),
      .row_vertex  (req_data.row_vertex),
      .row_bits    (req_data.row_bits),
      .last_vertex (last_vertex),
      .color_count (color_count_ff),
      .flags       (flags),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_data    (rsp_data)
   );

endmodule

@@ rtl/core/gcb_ucode_rom.sv @@
// microprogram table: one control word per step
module gcb_ucode_rom import gcb_pkg::*; (
   input  upc_type  upc,
   output ctrl_type ctrl
);

   always_comb begin
      case (upc)
         STEP_START:     ctrl = '{UOP_LOAD_K,    COND_EXH,        1'b0, STEP_EXH_OUT};
         STEP_INC:       ctrl = '{UOP_INC_COLOR, COND_NEVER,      1'b0, STEP_START};
         STEP_ZERO:      ctrl = '{UOP_NOP,       COND_COLOR_ZERO, 1'b0, STEP_BACK};
         STEP_CHECK:     ctrl = '{UOP_NOP,       COND_CONFLICT,   1'b0, STEP_INC};
         STEP_LASTV:     ctrl = '{UOP_NOP,       COND_K_LAST,     1'b0, STEP_EMIT};
         STEP_DEEP:      ctrl = '{UOP_K_UP,      COND_ALWAYS,     1'b0, STEP_INC};
         STEP_BACK:      ctrl = '{UOP_NOP,       COND_K_ZERO,     1'b0, STEP_EXH};
         STEP_BACK2:     ctrl = '{UOP_K_DOWN,    COND_ALWAYS,     1'b0, STEP_INC};
         STEP_EXH:       ctrl = '{UOP_SET_EXH,   COND_NEVER,      1'b0, STEP_START};
         STEP_EXH_OUT:   ctrl = '{UOP_EMIT_NONE, COND_ALWAYS,     1'b1, STEP_DONE};
         STEP_EMIT:      ctrl = '{UOP_SET_SOL,   COND_NEVER,      1'b0, STEP_START};
         STEP_EMIT_LOOP: ctrl = '{UOP_EMIT_SOL,  COND_K_NOT_LAST, 1'b1, STEP_EMIT_LOOP};
         STEP_DONE:      ctrl = '{UOP_END,       COND_NEVER,      1'b0, STEP_START};
         default:        ctrl = '{UOP_END,       COND_NEVER,      1'b0, STEP_START};
      endcase
   end

endmodule

@@ rtl/core/gcb_sequencer.sv @@
// step counter with conditional jumps, issues control words to the datapath
module gcb_sequencer import gcb_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   input  logic      start,
   input  flags_type flags,
   output logic      busy,
   output ctrl_type  ctrl_out
);

   upc_type  pc_ff, pc_in;
   logic     busy_ff, busy_in;
   ctrl_type ctrl;
   logic     stall;
   logic     take;

   gcb_ucode_rom u_rom (
      .upc  (pc_ff),
      .ctrl (ctrl)
   );

   always_comb begin
      case (ctrl.cond)
         COND_NEVER:      take = 1'b0;
         COND_ALWAYS:     take = 1'b1;
         COND_EXH:        take = flags.exhausted;
         COND_COLOR_ZERO: take = flags.color_zero;
         COND_CONFLICT:   take = flags.conflict;
         COND_K_LAST:     take = flags.k_last;
         COND_K_ZERO:     take = flags.k_zero;
         COND_K_NOT_LAST: take = !flags.k_last;
         default:         take = 1'b0;
      endcase
   end

   // emit steps hold while the output register is still full
   assign stall = ctrl.wait_out && flags.out_busy;

   always_comb begin
      pc_in   = pc_ff;
      busy_in = busy_ff;
      if (!busy_ff) begin
         if (start) begin
            busy_in = 1'b1;
            pc_in   = STEP_START;
         end
      end else if (!stall) begin
         if (ctrl.uop == UOP_END) begin
            busy_in = 1'b0;
         end else if (take) begin
            pc_in = ctrl.target;
         end else begin
            pc_in = pc_ff + upc_type'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff   <= STEP_START;
         busy_ff <= 1'b0;
      end else begin
         pc_ff   <= pc_in;
         busy_ff <= busy_in;
      end
   end

   always_comb begin
      ctrl_out = ctrl;
      if (!busy_ff || stall) begin
         ctrl_out.uop = UOP_NOP;
      end
   end

   assign busy = busy_ff;

endmodule

@@ rtl/core/gcb_datapath.sv @@
// adjacency rows, vertex colors, search position and the output register
module gcb_datapath import gcb_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  ctrl_type            ctrl,
   input  logic                load_row,
   input  logic                restart,
   input  logic [VERT_W-1:0]   row_vertex,
   input  logic [MAX_VERTICES-1:0] row_bits,
   input  logic [VERT_W-1:0]   last_vertex,
   input  logic [COLOR_W-1:0]  color_count,
   output flags_type           flags,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output rsp_type             rsp_data
);

   typedef enum logic [1:0] {
      STATUS_FRESH,
      STATUS_SOLUTION,
      STATUS_EXHAUSTED
   } status_type;

   logic [MAX_VERTICES-1:0] adj_ff [MAX_VERTICES];
   logic [COLOR_W-1:0]      colors_ff [MAX_VERTICES];
   logic [VERT_W-1:0]       k_ff;
   status_type              status_ff;
   logic                    rsp_valid_ff;
   rsp_type                 rsp_ff;

   logic [COLOR_W-1:0] color_k;
   logic [COLOR_W:0]   color_inc;
   logic [COLOR_W-1:0] color_next;
   logic [VERT_W-1:0]  k_up;
   logic               conflict;
   logic               out_busy;
   logic               emit;

   assign color_k    = colors_ff[k_ff];
   assign color_inc  = {1'b0, color_k} + (COLOR_W+1)'(1);
   // past the color limit wraps to zero, which means backtrack
   assign color_next = (color_inc > {1'b0, color_count}) ? '0 : color_inc[COLOR_W-1:0];
   assign k_up       = k_ff + VERT_W'(1);

   always_comb begin
      conflict = 1'b0;
      for (int j = 0; j < MAX_VERTICES; j++) begin
         if (VERT_W'(j) < k_ff && adj_ff[j][k_ff] && colors_ff[j] == color_k) begin
            conflict = 1'b1;
         end
      end
   end

   assign out_busy = rsp_valid_ff && !rsp_ready;
   assign emit     = (ctrl.uop == UOP_EMIT_NONE) || (ctrl.uop == UOP_EMIT_SOL);

   assign flags.exhausted  = (status_ff == STATUS_EXHAUSTED);
   assign flags.color_zero = (color_k == '0);
   assign flags.conflict   = conflict;
   assign flags.k_last     = (k_ff == last_vertex);
   assign flags.k_zero     = (k_ff == '0);
   assign flags.out_busy   = out_busy;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < MAX_VERTICES; i++) begin
            adj_ff[i]    <= '0;
            colors_ff[i] <= '0;
         end
         k_ff         <= '0;
         status_ff    <= STATUS_FRESH;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (load_row) begin
            adj_ff[row_vertex] <= row_bits;
         end
         if (restart) begin
            for (int i = 0; i < MAX_VERTICES; i++) begin
               colors_ff[i] <= '0;
            end
            k_ff      <= '0;
            status_ff <= STATUS_FRESH;
         end
         case (ctrl.uop)
            UOP_LOAD_K: begin
               k_ff <= (status_ff == STATUS_SOLUTION) ? last_vertex : '0;
            end
            UOP_INC_COLOR: begin
               colors_ff[k_ff] <= color_next;
            end
            UOP_K_UP: begin
               k_ff            <= k_up;
               colors_ff[k_up] <= '0;
            end
            UOP_K_DOWN: begin
               k_ff <= k_ff - VERT_W'(1);
            end
            UOP_SET_EXH: begin
               status_ff <= STATUS_EXHAUSTED;
               k_ff      <= '0;
            end
            UOP_SET_SOL: begin
               status_ff <= STATUS_SOLUTION;
               k_ff      <= '0;
            end
            UOP_EMIT_SOL: begin
               // walk k through the solution, stopping on the last vertex
               if (k_ff != last_vertex) begin
                  k_ff <= k_up;
               end
            end
            default: begin
            end
         endcase
         if (emit) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.uop == UOP_EMIT_SOL) begin
         rsp_ff <= '{k_ff, color_k, 1'b1, (k_ff == last_vertex)};
      end else if (ctrl.uop == UOP_EMIT_NONE) begin
         rsp_ff <= '{'0, '0, 1'b0, 1'b1};
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule
